@@ hdl/lef3_pkg.sv @@
`default_nettype none

package lef3_pkg;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int PIXEL_BITS_DEF = 8;

  localparam int FW_W     = 11;
  localparam int FH_W     = 12;
  localparam int GREY_W   = 8;
  localparam int ROW_W    = 12;
  localparam int OUT_COL_W = 10;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 12;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1,
    CFG_MAX_VALUE    = 2'd2
  } cfg_index_t;

  localparam logic [FW_W-1:0]   FRAME_WIDTH_RST  = FW_W'(640);
  localparam logic [FH_W-1:0]   FRAME_HEIGHT_RST = FH_W'(480);
  localparam logic [GREY_W-1:0] MAX_VALUE_RST    = GREY_W'(255);

  typedef struct packed {
    logic [GREY_W-1:0]    grey_value;
    logic [ROW_W-1:0]     pixel_row;
    logic [OUT_COL_W-1:0] pixel_col;
    logic                 last_of_run;
  } result_t;

endpackage

`default_nettype wire

@@ hdl/lef3_pixel_if.sv @@
`default_nettype none

interface lef3_pixel_if
  import lef3_pkg::*;
#(
  parameter int PIXEL_BITS = PIXEL_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [PIXEL_BITS-1:0] red_sample;

  modport source (output valid, output red_sample, input ready);
  modport sink (input valid, input red_sample, output ready);
endinterface

`default_nettype wire

@@ hdl/lef3_result_if.sv @@
`default_nettype none

interface lef3_result_if
  import lef3_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [GREY_W-1:0]    grey_value;
  logic [ROW_W-1:0]     pixel_row;
  logic [OUT_COL_W-1:0] pixel_col;
  logic                 last_of_run;

  modport source (output valid, output grey_value, output pixel_row, output pixel_col,
                  output last_of_run, input ready);
  modport sink (input valid, input grey_value, input pixel_row, input pixel_col,
                input last_of_run, output ready);
endinterface

`default_nettype wire

@@ hdl/lef3_ram.sv @@
`default_nettype none

module lef3_ram #(
  parameter int DEPTH  = 1024,
  parameter int DATA_W = 8,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ hdl/lef3_kernel.sv @@
`default_nettype none

module lef3_kernel
  import lef3_pkg::*;
#(
  parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
  input  wire logic [PIXEL_BITS-1:0] win [3][3],
  input  wire logic [GREY_W-1:0]     max_value,
  output logic      [GREY_W-1:0]     grey_value
);

  localparam int ACC_W = PIXEL_BITS + 5;
  localparam int CMP_W = (ACC_W > GREY_W + 1) ? ACC_W : GREY_W + 1;

  logic [ACC_W-1:0]        nsum;
  logic [ACC_W-1:0]        center8;
  logic signed [CMP_W-1:0] t;
  logic signed [CMP_W-1:0] lim;

  always_comb begin
    nsum = '0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        if (i != 1 || j != 1) begin
          nsum = nsum + ACC_W'(win[i][j]);
        end
      end
    end
  end

  assign center8 = ACC_W'(win[1][1]) << 3;
  assign t       = CMP_W'(signed'(center8 - nsum));
  assign lim     = signed'(CMP_W'(max_value));

  always_comb begin
    priority if (t < 0) begin
      grey_value = '0;
    end else if (t > lim) begin
      grey_value = max_value;
    end else begin
      grey_value = t[GREY_W-1:0];
    end
  end

endmodule

`default_nettype wire

@@ hdl/laplacian_edge_filter_3x3_unit.sv @@
// A pixel accepted at the input is held in the input stage; its results enter the output
// queue when that stage steps, which waits for room, and leave it one at a time from its head.
// Throughput: one pixel per cycle while each pixel causes at most one result and res.ready
// is high; a pixel with two results waits in the input stage until the queue has room.
// Reset clears the counters, window, pipeline and output queue and loads the registers with
// 640, 480 and 255; the line stores are not cleared and hold stale data until written.
`default_nettype none

module laplacian_edge_filter_3x3_unit
  import lef3_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  lef3_pixel_if.sink                  pix,
  lef3_result_if.source               res
);

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int WCMP_W = ($clog2(MAX_WIDTH + 1) > FW_W) ? $clog2(MAX_WIDTH + 1) : FW_W;

  logic [FW_W-1:0]   frame_width;
  logic [FH_W-1:0]   frame_height;
  logic [GREY_W-1:0] max_value;

  logic [COL_W-1:0]  col;
  logic [ROW_W-1:0]  row;
  logic [COL_W-1:0]  last_col;
  logic [ROW_W-1:0]  last_row;
  logic [WCMP_W-1:0] fw_ext;

  logic                  a_valid;
  logic [PIXEL_BITS-1:0] a_sample;
  logic [COL_W-1:0]      a_col;
  logic [ROW_W-1:0]      a_row;
  logic                  a_int;
  logic                  a_bord;
  logic                  a_fwd;
  logic [PIXEL_BITS-1:0] a_fwd_up;
  logic [PIXEL_BITS-1:0] a_fwd_lo;

  logic [PIXEL_BITS-1:0] up_rd;
  logic [PIXEL_BITS-1:0] lo_rd;
  logic [PIXEL_BITS-1:0] up_eff;
  logic [PIXEL_BITS-1:0] lo_eff;

  logic [PIXEL_BITS-1:0] win      [3][3];
  logic [PIXEL_BITS-1:0] win_next [3][3];
  logic [GREY_W-1:0]     grey;

  result_t    q0, q1, q0_next, q1_next;
  result_t    int_res, bord_res, r_first;
  logic [1:0] count, count_next, cnt_pop, n;
  logic       pop, step, accept;

  // geometry
  assign fw_ext = WCMP_W'(frame_width);

  always_comb begin
    priority if (frame_width == '0) begin
      last_col = '0;
    end else if (fw_ext > WCMP_W'(MAX_WIDTH)) begin
      last_col = COL_W'(MAX_WIDTH - 1);
    end else begin
      last_col = COL_W'(fw_ext - WCMP_W'(1));
    end
  end

  assign last_row = (frame_height == '0) ? '0 : frame_height - FH_W'(1);

  // handshakes
  assign pop      = (count != 2'd0) && res.ready;
  assign cnt_pop  = count - {1'b0, pop};
  assign n        = {1'b0, a_int} + {1'b0, a_bord};
  assign step     = a_valid && (n <= (2'd2 - cnt_pop));
  assign pix.ready = !a_valid || step;
  assign accept   = pix.valid && pix.ready;

  // configuration and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_WIDTH_RST;
      frame_height <= FRAME_HEIGHT_RST;
      max_value    <= MAX_VALUE_RST;
      col          <= '0;
      row          <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_FRAME_WIDTH: begin
          frame_width <= cfg_data[FW_W-1:0];
          col         <= '0;
          row         <= '0;
        end
        CFG_FRAME_HEIGHT: begin
          frame_height <= cfg_data[FH_W-1:0];
          col          <= '0;
          row          <= '0;
        end
        CFG_MAX_VALUE: begin
          max_value <= cfg_data[GREY_W-1:0];
        end
        default: begin
        end
      endcase
    end else if (accept) begin
      if (col == last_col) begin
        col <= '0;
        row <= (row == last_row) ? '0 : row + ROW_W'(1);
      end else begin
        col <= col + COL_W'(1);
      end
    end
  end

  // input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (accept) begin
      a_valid <= 1'b1;
    end else if (step) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_sample <= pix.red_sample;
      a_col    <= col;
      a_row    <= row;
      a_int    <= (row >= ROW_W'(2)) && (col >= COL_W'(2));
      a_bord   <= (row == '0) || (col == '0) || (row == last_row) || (col == last_col);
      a_fwd    <= step && (a_col == col);
      a_fwd_up <= lo_eff;
      a_fwd_lo <= a_sample;
    end
  end

  lef3_ram #(
    .DEPTH  (MAX_WIDTH),
    .DATA_W (PIXEL_BITS)
  ) u_upper (
    .clk   (clk),
    .we    (step),
    .waddr (a_col),
    .wdata (lo_eff),
    .re    (accept),
    .raddr (col),
    .rdata (up_rd)
  );

  lef3_ram #(
    .DEPTH  (MAX_WIDTH),
    .DATA_W (PIXEL_BITS)
  ) u_lower (
    .clk   (clk),
    .we    (step),
    .waddr (a_col),
    .wdata (a_sample),
    .re    (accept),
    .raddr (col),
    .rdata (lo_rd)
  );

  assign up_eff = a_fwd ? a_fwd_up : up_rd;
  assign lo_eff = a_fwd ? a_fwd_lo : lo_rd;

  // window
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      win_next[i][0] = win[i][1];
      win_next[i][1] = win[i][2];
    end
    win_next[0][2] = up_eff;
    win_next[1][2] = lo_eff;
    win_next[2][2] = a_sample;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win[i][j] <= '0;
        end
      end
    end else if (step) begin
      win <= win_next;
    end
  end

  lef3_kernel #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_kernel (
    .win        (win_next),
    .max_value  (max_value),
    .grey_value (grey)
  );

  // results
  always_comb begin
    int_res.grey_value  = grey;
    int_res.pixel_row   = a_row - ROW_W'(1);
    int_res.pixel_col   = OUT_COL_W'(a_col - COL_W'(1));
    int_res.last_of_run = !a_bord;
    bord_res.grey_value  = '0;
    bord_res.pixel_row   = a_row;
    bord_res.pixel_col   = OUT_COL_W'(a_col);
    bord_res.last_of_run = 1'b1;
    r_first = a_int ? int_res : bord_res;
  end

  always_comb begin
    q0_next = q0;
    q1_next = q1;
    if (pop) begin
      q0_next = q1;
    end
    if (step) begin
      if (cnt_pop == 2'd0) begin
        if (n != 2'd0) begin
          q0_next = r_first;
        end
        if (n == 2'd2) begin
          q1_next = bord_res;
        end
      end else if (n != 2'd0) begin
        q1_next = r_first;
      end
    end
    count_next = cnt_pop + (step ? n : 2'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    q0 <= q0_next;
    q1 <= q1_next;
  end

  assign res.valid       = (count != 2'd0);
  assign res.grey_value  = q0.grey_value;
  assign res.pixel_row   = q0.pixel_row;
  assign res.pixel_col   = q0.pixel_col;
  assign res.last_of_run = q0.last_of_run;

endmodule

`default_nettype wire

@@ test/tb_top.sv @@
module tb_top;
  import lef3_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_IDX = 2'd3;
  localparam int QUIET_EDGES = 6;
  localparam int HOLD_CYCLES = 150;
  localparam int PRINT_CAP = 40;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  lef3_pixel_if pix_bus ();
  lef3_result_if res_bus ();

  laplacian_edge_filter_3x3_unit dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .pix(pix_bus),
    .res(res_bus)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [7:0] red_queue[$];
  result_t results_due[$];
  int mismatches = 0;
  logic calm;
  logic squeeze_go;
  logic hold_off;
  int send_gap;
  int recv_stall;

  int geo_w = FRAME_WIDTH_RST;
  int geo_h = FRAME_HEIGHT_RST;
  int clamp_max = MAX_VALUE_RST;
  int upper_row[MAX_WIDTH_DEF] = '{default: 0};
  int lower_row[MAX_WIDTH_DEF] = '{default: 0};
  int win[3][3] = '{default: 0};
  int cur_row = 0;
  int cur_col = 0;

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= PRINT_CAP) $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  task automatic laplace_step(input logic [7:0] sample);
    int wid;
    int hgt;
    int r;
    int c;
    int sum;
    int acc;
    int n;
    int up;
    int lo;
    result_t outs[2];
    wid = (geo_w == 0) ? 1 : ((geo_w > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : geo_w);
    hgt = (geo_h == 0) ? 1 : geo_h;
    r = cur_row;
    c = cur_col;
    n = 0;
    up = upper_row[c];
    lo = lower_row[c];
    upper_row[c] = lo;
    lower_row[c] = int'(sample);
    for (int i = 0; i < 3; i++) begin
      win[i][0] = win[i][1];
      win[i][1] = win[i][2];
    end
    win[0][2] = up;
    win[1][2] = lo;
    win[2][2] = int'(sample);
    if (r >= 2 && c >= 2) begin
      sum = 0;
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++)
          if (i != 1 || j != 1) sum += win[i][j];
      acc = 8 * win[1][1] - sum;
      if (acc > clamp_max) acc = clamp_max;
      else if (acc < 0) acc = 0;
      outs[n].grey_value = GREY_W'(acc);
      outs[n].pixel_row = ROW_W'(r - 1);
      outs[n].pixel_col = OUT_COL_W'(c - 1);
      outs[n].last_of_run = 1'b0;
      n++;
    end
    if (r == 0 || c == 0 || r == hgt - 1 || c == wid - 1) begin
      outs[n].grey_value = '0;
      outs[n].pixel_row = ROW_W'(r);
      outs[n].pixel_col = OUT_COL_W'(c);
      outs[n].last_of_run = 1'b0;
      n++;
    end
    if (n > 0) outs[n-1].last_of_run = 1'b1;
    for (int k = 0; k < n; k++) results_due.push_back(outs[k]);
    c++;
    if (c >= wid) begin
      c = 0;
      r++;
      if (r >= hgt) r = 0;
    end
    cur_col = c;
    cur_row = r;
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_FRAME_WIDTH: begin
        geo_w = int'(val[FW_W-1:0]);
        cur_row = 0;
        cur_col = 0;
      end
      CFG_FRAME_HEIGHT: begin
        geo_h = int'(val[FH_W-1:0]);
        cur_row = 0;
        cur_col = 0;
      end
      CFG_MAX_VALUE: clamp_max = int'(val[GREY_W-1:0]);
      default: ;
    endcase
  endtask

  task automatic settle();
    int quiet;
    quiet = 0;
    while (quiet < QUIET_EDGES) begin
      @(posedge clk);
      if (red_queue.size() == 0 && !pix_bus.valid && results_due.size() == 0) quiet++;
      else quiet = 0;
    end
  endtask

  function automatic logic [7:0] pick_sample();
    case ($urandom_range(0, 3))
      0: return 8'($urandom_range(0, 255));
      1: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      default: return 8'(96 + $urandom_range(0, 48));
    endcase
  endfunction

  task automatic feed_random(input int n);
    repeat (n) red_queue.push_back(pick_sample());
  endtask

  task automatic new_geometry(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h,
                              input logic [CFG_DATA_W-1:0] mx, input int n);
    settle();
    write_reg(CFG_FRAME_WIDTH, w);
    write_reg(CFG_FRAME_HEIGHT, h);
    write_reg(CFG_MAX_VALUE, mx);
    feed_random(n);
  endtask

  always @(posedge clk) begin : pixel_drv
    if (rst) begin
      pix_bus.valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (pix_bus.valid && pix_bus.ready) laplace_step(pix_bus.red_sample);
      if (!(pix_bus.valid && !pix_bus.ready)) begin
        if (send_gap > 0) begin
          send_gap--;
          pix_bus.valid <= 1'b0;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
          send_gap = $urandom_range(0, 6);
          pix_bus.valid <= 1'b0;
        end else if (red_queue.size() != 0) begin
          pix_bus.valid <= 1'b1;
          pix_bus.red_sample <= red_queue.pop_front();
        end else begin
          pix_bus.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : result_mon
    result_t want;
    if (rst) begin
      res_bus.ready <= 1'b0;
      recv_stall = 0;
    end else begin
      if (res_bus.valid && res_bus.ready) begin
        if (results_due.size() == 0) begin
          report_mismatch($sformatf("unexpected result row %0d col %0d grey %0d",
                                    res_bus.pixel_row, res_bus.pixel_col, res_bus.grey_value));
        end else begin
          want = results_due.pop_front();
          if (res_bus.grey_value !== want.grey_value)
            report_mismatch($sformatf("grey at (%0d,%0d): got %0d, want %0d", want.pixel_row,
                                      want.pixel_col, res_bus.grey_value, want.grey_value));
          if (res_bus.pixel_row !== want.pixel_row)
            report_mismatch($sformatf("row: got %0d, want %0d", res_bus.pixel_row,
                                      want.pixel_row));
          if (res_bus.pixel_col !== want.pixel_col)
            report_mismatch($sformatf("col: got %0d, want %0d", res_bus.pixel_col,
                                      want.pixel_col));
          if (res_bus.last_of_run !== want.last_of_run)
            report_mismatch($sformatf("last at (%0d,%0d): got %b, want %b", want.pixel_row,
                                      want.pixel_col, res_bus.last_of_run, want.last_of_run));
        end
      end
      if (recv_stall > 0) recv_stall--;
      else if (!calm && $urandom_range(0, 7) == 0) recv_stall = $urandom_range(1, 7);
      res_bus.ready <= !hold_off && (recv_stall == 0);
    end
  end

  // hold the result side off long enough to back up the pixel input
  initial begin
    hold_off = 1'b0;
    wait (squeeze_go === 1'b1);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = CFG_FRAME_WIDTH;
    cfg_data = '0;
    pix_bus.valid = 1'b0;
    pix_bus.red_sample = '0;
    res_bus.ready = 1'b0;
    calm = 1'b0;
    squeeze_go = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    red_queue.push_back(8'hFF);
    red_queue.push_back(8'h00);
    red_queue.push_back(8'h80);
    settle();
    write_reg(CFG_FRAME_WIDTH, 12'd3);
    write_reg(CFG_FRAME_HEIGHT, 12'd3);
    write_reg(CFG_MAX_VALUE, 12'd255);
    for (int k = 0; k < 9; k++) red_queue.push_back((k == 4) ? 8'hFF : 8'h00);
    for (int k = 0; k < 9; k++) red_queue.push_back((k == 4) ? 8'h00 : 8'hFF);

    new_geometry(12'd8, 12'd6, 12'd200, 64);
    squeeze_go <= 1'b1;
    new_geometry(12'd0, 12'd5, 12'd0, 12);
    new_geometry(12'd2, 12'd0, 12'd255, 10);
    new_geometry(12'd1, 12'd1, 12'd255, 6);
    new_geometry(12'd4, 12'hFFF, 12'd255, 40);
    new_geometry(12'hFFF, 12'd2, 12'd255, 30);
    new_geometry(12'd1024, 12'd3, 12'hF80, 24);
    new_geometry(12'd7, 12'd5, 12'd90, 40);
    settle();
    write_reg(CFG_SPARE_IDX, 12'($urandom_range(0, 4095)));
    feed_random(40);
    repeat (2) begin
      new_geometry(12'($urandom_range(1, 12)), 12'($urandom_range(1, 8)),
                   12'($urandom_range(0, 255)), $urandom_range(20, 60));
    end

    settle();
    calm <= 1'b1;
    new_geometry(12'd6, 12'd4, 12'd255, 60);
    settle();

    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/lef3_pkg.sv
hdl/lef3_pixel_if.sv
hdl/lef3_result_if.sv
hdl/lef3_ram.sv
hdl/lef3_kernel.sv
hdl/laplacian_edge_filter_3x3_unit.sv
test/tb_top.sv
